### hw/rtl/ddc_pkg.sv
// ----------------------------------------------------------------------------
// ddc_pkg
// Shared types, constants and the sequencer program of the down-converter.
// ----------------------------------------------------------------------------
package ddc_pkg;

	localparam int SINE_TABLE_BITS_DEF  = 10;
	localparam int SAMPLE_BITS_DEF      = 16;
	localparam int FILTER_FRAC_BITS_DEF = 8;

	localparam int TRIG_W      = 16;
	localparam int TRIG_FRAC   = 15;
	localparam int ALPHA_W     = 16;
	localparam int INCREMENT_W = 32;
	localparam int PHASE_W     = 32;
	localparam int FACTOR_W    = 13;
	localparam int COUNT_W     = 12;
	localparam int MAX_DECIM   = 4096;
	localparam int DATA_W      = 32;
	localparam int PADDR_W     = 4;
	localparam int STEP_W      = 4;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		REG_INCREMENT = 2'd0,
		REG_ALPHA     = 2'd1,
		REG_DECIM     = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		MUL_A_SI    = 2'd0,
		MUL_A_SQ    = 2'd1,
		MUL_A_ALPHA = 2'd2
	} mul_a_t;

	typedef enum logic [1:0] {
		MUL_B_SIN    = 2'd0,
		MUL_B_COS    = 2'd1,
		MUL_B_DIFF_I = 2'd2,
		MUL_B_DIFF_Q = 2'd3
	} mul_b_t;

	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2,
		ACC_SUB  = 2'd3
	} acc_op_t;

	typedef enum logic [1:0] {
		SEQ_NEXT    = 2'd0,
		SEQ_WAIT_IN = 2'd1,
		SEQ_EMIT    = 2'd2,
		SEQ_RESTART = 2'd3
	} seq_t;

	typedef struct packed {
		logic    rom_cos;
		logic    ld_sin;
		logic    ld_cos;
		logic    adv_phase;
		mul_a_t  mul_a;
		mul_b_t  mul_b;
		acc_op_t acc_op;
		logic    wr_mi;
		logic    wr_mq;
		logic    wr_fi;
		logic    wr_fq;
		seq_t    seq;
	} ctl_t;

	localparam logic [STEP_W-1:0] STEP_ACCEPT  = 4'd0;
	localparam logic [STEP_W-1:0] STEP_SIN     = 4'd1;
	localparam logic [STEP_W-1:0] STEP_COS     = 4'd2;
	localparam logic [STEP_W-1:0] STEP_MQ_ADD  = 4'd3;
	localparam logic [STEP_W-1:0] STEP_MQ_DONE = 4'd4;
	localparam logic [STEP_W-1:0] STEP_MI_SUB  = 4'd5;
	localparam logic [STEP_W-1:0] STEP_MI_DONE = 4'd6;
	localparam logic [STEP_W-1:0] STEP_FQ_DONE = 4'd7;
	localparam logic [STEP_W-1:0] STEP_FI_DONE = 4'd8;
	localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd9;

	function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
		ctl_t c;
		c = '0;
		case (step)
			STEP_ACCEPT: begin
				c.seq = SEQ_WAIT_IN;
			end
			STEP_SIN: begin
				c.rom_cos = 1'b1;
				c.ld_sin  = 1'b1;
			end
			STEP_COS: begin
				c.ld_cos    = 1'b1;
				c.adv_phase = 1'b1;
				c.mul_a     = MUL_A_SI;
				c.mul_b     = MUL_B_SIN;
				c.acc_op    = ACC_LOAD;
			end
			STEP_MQ_ADD: begin
				c.mul_a  = MUL_A_SQ;
				c.mul_b  = MUL_B_COS;
				c.acc_op = ACC_ADD;
			end
			STEP_MQ_DONE: begin
				c.wr_mq  = 1'b1;
				c.mul_a  = MUL_A_SI;
				c.mul_b  = MUL_B_COS;
				c.acc_op = ACC_LOAD;
			end
			STEP_MI_SUB: begin
				c.mul_a  = MUL_A_SQ;
				c.mul_b  = MUL_B_SIN;
				c.acc_op = ACC_SUB;
			end
			STEP_MI_DONE: begin
				c.wr_mi  = 1'b1;
				c.mul_a  = MUL_A_ALPHA;
				c.mul_b  = MUL_B_DIFF_Q;
				c.acc_op = ACC_LOAD;
			end
			STEP_FQ_DONE: begin
				c.wr_fq  = 1'b1;
				c.mul_a  = MUL_A_ALPHA;
				c.mul_b  = MUL_B_DIFF_I;
				c.acc_op = ACC_LOAD;
			end
			STEP_FI_DONE: begin
				c.wr_fi = 1'b1;
			end
			STEP_EMIT: begin
				c.seq = SEQ_EMIT;
			end
			default: begin
				c.seq = SEQ_RESTART;
			end
		endcase
		return c;
	endfunction

	function automatic logic [63:0] taylor_next(input logic [63:0] term, input logic [63:0] x);
		return (((term * x) >> 30) * x) >> 30;
	endfunction

	// quarter-wave sine magnitude in unsigned Q0.15, k in 0..2^qbits
	function automatic logic [TRIG_FRAC-1:0] quarter_sine(input int unsigned k,
			input int unsigned qbits);
		logic [63:0]        x;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic signed [63:0] r;
		x    = (64'(k) * HALF_PI_Q30) >> qbits;
		term = x;
		sum  = $signed(x);
		term = taylor_next(term, x) / 64'd6;
		sum  = sum - $signed(term);
		term = taylor_next(term, x) / 64'd20;
		sum  = sum + $signed(term);
		term = taylor_next(term, x) / 64'd42;
		sum  = sum - $signed(term);
		term = taylor_next(term, x) / 64'd72;
		sum  = sum + $signed(term);
		term = taylor_next(term, x) / 64'd110;
		sum  = sum - $signed(term);
		term = taylor_next(term, x) / 64'd156;
		sum  = sum + $signed(term);
		term = taylor_next(term, x) / 64'd210;
		sum  = sum - $signed(term);
		if (sum < 0)
			sum = 0;
		r = (sum + 64'sd16384) >>> 15;
		if (r > 64'sd32767)
			r = 64'sd32767;
		return r[TRIG_FRAC-1:0];
	endfunction

endpackage

### hw/rtl/ddc_channels.sv
// ----------------------------------------------------------------------------
// ddc channels
// Valid/ready channels for input samples and decimated baseband words.
// ----------------------------------------------------------------------------
interface ddc_sample_if import ddc_pkg::*; #(
	parameter int W = SAMPLE_BITS_DEF
) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] sample_i;
	logic signed [W-1:0] sample_q;

	modport source (output valid, output sample_i, output sample_q, input ready);
	modport sink (input valid, input sample_i, input sample_q, output ready);
endinterface

interface ddc_baseband_if import ddc_pkg::*; #(
	parameter int W = SAMPLE_BITS_DEF
) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] out_i;
	logic signed [W-1:0] out_q;

	modport source (output valid, output out_i, output out_q, input ready);
	modport sink (input valid, input out_i, input out_q, output ready);
endinterface

### hw/rtl/ddc_mixer_lowpass_decimator_core.sv
// ----------------------------------------------------------------------------
// ddc_mixer_lowpass_decimator_core
// NCO mixer, one-pole low-pass and decimator run by a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  samples    in   valid/ready    sample_i, sample_q
//  baseband   out  valid/ready    out_i, out_q
//  apb        cfg  psel/penable   paddr, pwdata, prdata (pready tied high)
//
//  One sample at a time: a ten-step program drives one shared multiplier
//  through the six products (four mixer terms, two filter updates).
//  The baseband word sits in an output register; the sequencer stalls on output
//  only when it is still held at the emit step of the next decimated word.
//  arst_n clears phase, filter state, counter and output valid and resets registers.
// ----------------------------------------------------------------------------
module ddc_mixer_lowpass_decimator_core import ddc_pkg::*; #(
	parameter int SINE_TABLE_BITS  = SINE_TABLE_BITS_DEF,
	parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
	parameter int FILTER_FRAC_BITS = FILTER_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ddc_sample_if.sink           samples,
	ddc_baseband_if.source       baseband,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready
);
	localparam int FILT_W = SAMPLE_BITS + FILTER_FRAC_BITS;
	localparam int DIFF_W = FILT_W + 1;
	localparam int A_W    = (SAMPLE_BITS > ALPHA_W + 1) ? SAMPLE_BITS : ALPHA_W + 1;
	localparam int B_W    = (DIFF_W > TRIG_W) ? DIFF_W : TRIG_W;
	localparam int P_W    = A_W + B_W;
	localparam int ACC_W  = P_W + 1;

	localparam logic signed [63:0] S_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] S_MIN = -S_MAX - 64'sd1;
	localparam logic signed [63:0] F_MAX = (64'sd1 <<< (FILT_W - 1)) - 64'sd1;
	localparam logic signed [63:0] F_MIN = -F_MAX - 64'sd1;
	localparam logic signed [63:0] F_HALF =
		(FILTER_FRAC_BITS > 0) ? (64'sd1 <<< FILTER_FRAC_BITS) >>> 1 : 64'sd0;

	localparam logic [INCREMENT_W-1:0] RST_INCREMENT = '0;
	localparam logic [ALPHA_W-1:0]     RST_ALPHA     = 16'd32768;
	localparam logic [FACTOR_W-1:0]    RST_FACTOR    = 13'd1;

	function automatic logic signed [SAMPLE_BITS-1:0] mix_round(
			input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] v;
		v = (acc + ACC_W'(64'sd16384)) >>> TRIG_FRAC;
		if (v > ACC_W'(S_MAX))
			return SAMPLE_BITS'(S_MAX);
		else if (v < ACC_W'(S_MIN))
			return SAMPLE_BITS'(S_MIN);
		return v[SAMPLE_BITS-1:0];
	endfunction

	function automatic logic signed [FILT_W-1:0] filt_update(
			input logic signed [FILT_W-1:0] st, input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] v;
		v = ((acc + ACC_W'(64'sd32768)) >>> ALPHA_W) + ACC_W'(st);
		if (v > ACC_W'(F_MAX))
			return FILT_W'(F_MAX);
		else if (v < ACC_W'(F_MIN))
			return FILT_W'(F_MIN);
		return v[FILT_W-1:0];
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] out_round(
			input logic signed [FILT_W-1:0] st);
		logic signed [DIFF_W-1:0] v;
		v = (DIFF_W'(st) + DIFF_W'(F_HALF)) >>> FILTER_FRAC_BITS;
		if (v > DIFF_W'(S_MAX))
			return SAMPLE_BITS'(S_MAX);
		else if (v < DIFF_W'(S_MIN))
			return SAMPLE_BITS'(S_MIN);
		return v[SAMPLE_BITS-1:0];
	endfunction

	logic [INCREMENT_W-1:0]           increment_q;
	logic [ALPHA_W-1:0]               alpha_q;
	logic [FACTOR_W-1:0]              factor_q;
	logic [PHASE_W-1:0]               phase_q;
	logic [STEP_W-1:0]                step_q;
	logic [COUNT_W-1:0]               count_q;
	logic signed [SAMPLE_BITS-1:0]    si_q;
	logic signed [SAMPLE_BITS-1:0]    sq_q;
	logic signed [TRIG_W-1:0]         sin_q;
	logic signed [TRIG_W-1:0]         cos_q;
	logic signed [ACC_W-1:0]          acc_q;
	logic signed [SAMPLE_BITS-1:0]    mi_q;
	logic signed [SAMPLE_BITS-1:0]    mq_q;
	logic signed [FILT_W-1:0]         fi_q;
	logic signed [FILT_W-1:0]         fq_q;
	logic                             out_valid_q;
	logic signed [SAMPLE_BITS-1:0]    out_i_q;
	logic signed [SAMPLE_BITS-1:0]    out_q_q;

	ctl_t                             ctl;
	logic signed [TRIG_W-1:0]         trig;
	logic signed [A_W-1:0]            mul_a;
	logic signed [B_W-1:0]            mul_b;
	logic signed [P_W-1:0]            prod;
	logic signed [DIFF_W-1:0]         diff_i;
	logic signed [DIFF_W-1:0]         diff_q;
	logic                             in_fire;
	logic                             emit;
	logic                             slot_free;
	logic [FACTOR_W-1:0]              factor_eff;
	logic [FACTOR_W-1:0]              count_next;
	logic                             cfg_write;

	ddc_sine_rom #(
		.TABLE_BITS (SINE_TABLE_BITS)
	) u_rom (
		.clk       (clk),
		.phase_idx (phase_q[PHASE_W-1 -: SINE_TABLE_BITS]),
		.sel_cos   (ctl.rom_cos),
		.trig      (trig)
	);

	assign ctl = ucode(step_q);

	assign samples.ready  = (ctl.seq == SEQ_WAIT_IN);
	assign in_fire        = samples.valid && samples.ready;
	assign baseband.valid = out_valid_q;
	assign baseband.out_i = out_i_q;
	assign baseband.out_q = out_q_q;
	assign slot_free      = !out_valid_q || baseband.ready;
	assign emit           = (count_q == '0);

	always_comb begin
		diff_i = (DIFF_W'(mi_q) <<< FILTER_FRAC_BITS) - DIFF_W'(fi_q);
		diff_q = (DIFF_W'(mq_q) <<< FILTER_FRAC_BITS) - DIFF_W'(fq_q);
		case (ctl.mul_a)
			MUL_A_SI:    mul_a = A_W'(si_q);
			MUL_A_SQ:    mul_a = A_W'(sq_q);
			MUL_A_ALPHA: mul_a = $signed(A_W'({1'b0, alpha_q}));
			default:     mul_a = '0;
		endcase
		case (ctl.mul_b)
			MUL_B_SIN:    mul_b = B_W'(sin_q);
			MUL_B_COS:    mul_b = B_W'(cos_q);
			MUL_B_DIFF_I: mul_b = B_W'(diff_i);
			MUL_B_DIFF_Q: mul_b = B_W'(diff_q);
			default:      mul_b = '0;
		endcase
		prod = mul_a * mul_b;
		if (factor_q == '0)
			factor_eff = FACTOR_W'(1);
		else if (factor_q > FACTOR_W'(MAX_DECIM))
			factor_eff = FACTOR_W'(MAX_DECIM);
		else
			factor_eff = factor_q;
		count_next = {1'b0, count_q} + FACTOR_W'(1);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			si_q <= samples.sample_i;
			sq_q <= samples.sample_q;
		end
		if (ctl.ld_sin)
			sin_q <= trig;
		if (ctl.ld_cos)
			cos_q <= trig;
		case (ctl.acc_op)
			ACC_LOAD: acc_q <= ACC_W'(prod);
			ACC_ADD:  acc_q <= acc_q + ACC_W'(prod);
			ACC_SUB:  acc_q <= acc_q - ACC_W'(prod);
			default:  acc_q <= acc_q;
		endcase
		if (ctl.wr_mi)
			mi_q <= mix_round(acc_q);
		if (ctl.wr_mq)
			mq_q <= mix_round(acc_q);
		if (ctl.seq == SEQ_EMIT && emit && slot_free) begin
			out_i_q <= out_round(fi_q);
			out_q_q <= out_round(fq_q);
		end
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_ACCEPT;
			phase_q     <= '0;
			fi_q        <= '0;
			fq_q        <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.adv_phase)
				phase_q <= phase_q + increment_q;
			if (ctl.wr_fi)
				fi_q <= filt_update(fi_q, acc_q);
			if (ctl.wr_fq)
				fq_q <= filt_update(fq_q, acc_q);
			if (ctl.seq == SEQ_EMIT && emit && slot_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && baseband.ready)
				out_valid_q <= 1'b0;
			case (ctl.seq)
				SEQ_WAIT_IN: begin
					if (in_fire)
						step_q <= step_q + STEP_W'(1);
				end
				SEQ_NEXT: begin
					step_q <= step_q + STEP_W'(1);
				end
				SEQ_EMIT: begin
					if (!emit || slot_free) begin
						step_q  <= STEP_ACCEPT;
						count_q <= (count_next >= factor_eff) ? '0 : count_next[COUNT_W-1:0];
					end
				end
				default: begin
					step_q <= STEP_ACCEPT;
				end
			endcase
		end
	end

	// configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			increment_q <= RST_INCREMENT;
			alpha_q     <= RST_ALPHA;
			factor_q    <= RST_FACTOR;
		end else if (cfg_write) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_INCREMENT: increment_q <= pwdata[INCREMENT_W-1:0];
				REG_ALPHA:     alpha_q     <= pwdata[ALPHA_W-1:0];
				REG_DECIM:     factor_q    <= pwdata[FACTOR_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_INCREMENT: prdata = increment_q;
			REG_ALPHA:     prdata = DATA_W'(alpha_q);
			REG_DECIM:     prdata = DATA_W'(factor_q);
			default:       prdata = '0;
		endcase
	end

endmodule

### hw/rtl/ddc_sine_rom.sv
// ----------------------------------------------------------------------------
// ddc_sine_rom
// Quarter-wave phasor table with registered read and quadrant folding.
// ----------------------------------------------------------------------------
module ddc_sine_rom import ddc_pkg::*; #(
	parameter int TABLE_BITS = SINE_TABLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic [TABLE_BITS-1:0]        phase_idx,
	input  logic                         sel_cos,
	output logic signed [TRIG_W-1:0]     trig
);
	localparam int QBITS   = TABLE_BITS - 2;
	localparam int QUARTER = 1 << QBITS;
	localparam int ADDR_W  = QBITS + 1;

	typedef logic [TRIG_FRAC-1:0] rom_t [QUARTER+1];

	function automatic rom_t build_rom();
		rom_t r;
		for (int k = 0; k <= QUARTER; k++)
			r[k] = quarter_sine(k, QBITS);
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic [TABLE_BITS-1:0]      idx;
	logic [1:0]                 quad;
	logic [QBITS-1:0]           rem;
	logic [ADDR_W-1:0]          addr;
	logic signed [TRIG_W-1:0]   mag;
	logic signed [TRIG_W-1:0]   trig_q;

	always_comb begin
		idx  = sel_cos ? phase_idx + TABLE_BITS'(QUARTER) : phase_idx;
		quad = idx[TABLE_BITS-1 -: 2];
		rem  = idx[QBITS-1:0];
		addr = quad[0] ? ADDR_W'(QUARTER) - {1'b0, rem} : {1'b0, rem};
		mag  = $signed({1'b0, SINE_ROM[addr]});
	end

	always_ff @(posedge clk) begin
		trig_q <= quad[1] ? -mag : mag;
	end

	assign trig = trig_q;

endmodule

### tb/ddc_baseband_checker.sv
// ----------------------------------------------------------------------------
// ddc_baseband_checker
// Watches the sample, baseband and APB ports of the down-converter, predicts
// every decimated baseband word from the accepted samples and the register
// writes, and compares each delivered word field by field in order.
// ----------------------------------------------------------------------------
module ddc_baseband_checker import ddc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	ddc_sample_if              samples,
	ddc_baseband_if            baseband,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TBITS   = SINE_TABLE_BITS_DEF;
	localparam int QBITS   = TBITS - 2;
	localparam int QUARTER = 1 << QBITS;
	localparam int SB      = SAMPLE_BITS_DEF;
	localparam int FB      = FILTER_FRAC_BITS_DEF;

	typedef struct packed {
		logic signed [SB-1:0] out_i;
		logic signed [SB-1:0] out_q;
	} baseband_word_t;

	longint sine_quarter [0:QUARTER];

	logic [INCREMENT_W-1:0] phase_step;
	logic [ALPHA_W-1:0]     alpha;
	logic [FACTOR_W-1:0]    decim_factor;

	logic [PHASE_W-1:0]       phase;
	logic signed [SB+FB-1:0]  lp_i;
	logic signed [SB+FB-1:0]  lp_q;
	logic [COUNT_W-1:0]       decim_count;

	baseband_word_t expected_words [$];

	function automatic longint taylor_sine_q15(input int unsigned k);
		longint unsigned x;
		longint unsigned term;
		longint          acc;
		longint          r;
		x    = (longint'(k) * 64'd1686629713) >> QBITS;
		term = x;
		acc  = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = (((term * x) >> 30) * x) >> 30;
			term = term / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		r = (acc + 16384) >>> 15;
		return (r > 32767) ? 32767 : r;
	endfunction

	function automatic longint phasor_sine(input logic [TBITS-1:0] idx);
		int unsigned r;
		r = int'(idx[QBITS-1:0]);
		case (idx[TBITS-1 -: 2])
			2'd0: return sine_quarter[r];
			2'd1: return sine_quarter[QUARTER - r];
			2'd2: return -sine_quarter[r];
			default: return -sine_quarter[QUARTER - r];
		endcase
	endfunction

	function automatic longint clamp_signed(input longint x, input int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		return (x > hi) ? hi : ((x < lo) ? lo : x);
	endfunction

	function automatic longint lowpass_step(input longint st, input longint mixed);
		longint diff;
		longint delta;
		diff  = (mixed <<< FB) - st;
		delta = (diff * longint'(alpha) + 32768) >>> 16;
		return clamp_signed(st + delta, SB + FB);
	endfunction

	function automatic longint round_state(input longint st);
		longint half;
		half = (FB > 0) ? (longint'(1) <<< FB) / 2 : 0;
		return clamp_signed((st + half) >>> FB, SB);
	endfunction

	task automatic mix_filter_decimate(input longint si, input longint sq);
		logic [TBITS-1:0] idx;
		longint           s;
		longint           c;
		longint           mi;
		longint           mq;
		int               factor;
		int               next;
		baseband_word_t   w;
		idx = phase[PHASE_W-1 -: TBITS];
		s   = phasor_sine(idx);
		c   = phasor_sine(idx + TBITS'(QUARTER));
		mi  = clamp_signed((si * c - sq * s + 16384) >>> 15, SB);
		mq  = clamp_signed((si * s + sq * c + 16384) >>> 15, SB);
		phase = phase + phase_step;
		lp_i  = (SB + FB)'(lowpass_step(longint'(lp_i), mi));
		lp_q  = (SB + FB)'(lowpass_step(longint'(lp_q), mq));
		if (decim_count == '0) begin
			w.out_i = SB'(round_state(longint'(lp_i)));
			w.out_q = SB'(round_state(longint'(lp_q)));
			expected_words.insert(expected_words.size(), w);
		end
		factor = int'(decim_factor);
		if (factor == 0)
			factor = 1;
		if (factor > MAX_DECIM)
			factor = MAX_DECIM;
		next = int'(decim_count) + 1;
		decim_count = (next >= factor) ? '0 : COUNT_W'(next);
	endtask

	initial begin
		for (int k = 0; k <= QUARTER; k++)
			sine_quarter[k] = taylor_sine_q15(k);
	end

	always @(posedge clk or negedge arst_n) begin
		baseband_word_t w;
		if (!arst_n) begin
			phase_step    = '0;
			alpha         = ALPHA_W'(32768);
			decim_factor  = FACTOR_W'(1);
			phase         = '0;
			lp_i          = '0;
			lp_q          = '0;
			decim_count   = '0;
			expected_words.delete();
			fail_count    = 0;
			pending       = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_INCREMENT: phase_step = pwdata[INCREMENT_W-1:0];
					REG_ALPHA: alpha = pwdata[ALPHA_W-1:0];
					REG_DECIM: decim_factor = pwdata[FACTOR_W-1:0];
					default: ;
				endcase
			end
			if (samples.valid && samples.ready)
				mix_filter_decimate(longint'(samples.sample_i), longint'(samples.sample_q));
			if (baseband.valid && baseband.ready) begin
				if (expected_words.size() == 0) begin
					$error("baseband word with nothing expected: out_i %0d out_q %0d",
						baseband.out_i, baseband.out_q);
					fail_count++;
				end else begin
					w = expected_words.pop_front();
					if (baseband.out_i !== w.out_i) begin
						$error("out_i: expected %0d, actual %0d", w.out_i, baseband.out_i);
						fail_count++;
					end
					if (baseband.out_q !== w.out_q) begin
						$error("out_q: expected %0d, actual %0d", w.out_q, baseband.out_q);
						fail_count++;
					end
				end
			end
			pending = expected_words.size();
		end
	end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Regression for the down-converter core: directed extremes and corner
// settings, then randomized register settings with random sample streams,
// random source gaps and sink stalls. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench import ddc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	int fail_count;
	int pending;
	int items_sent;
	bit src_burst;
	bit sink_burst;

	ddc_sample_if   sample_ch ();
	ddc_baseband_if baseband_ch ();

	ddc_mixer_lowpass_decimator_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (sample_ch),
		.baseband (baseband_ch),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	ddc_baseband_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.samples       (sample_ch),
		.baseband      (baseband_ch),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("ddc_mixer_lowpass_decimator_core regression: fail");
		$finish;
	end

	task automatic write_reg(input reg_idx_t r, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({r, 2'b00});
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// drain the pipeline before touching registers
	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (24) @(negedge clk);
	endtask

	task automatic configure(input logic [31:0] step, input logic [15:0] a,
			input logic [12:0] factor);
		settle();
		write_reg(REG_INCREMENT, step);
		@(negedge clk);
		write_reg(REG_ALPHA, DATA_W'(a));
		@(negedge clk);
		write_reg(REG_DECIM, DATA_W'(factor));
		@(negedge clk);
	endtask

	task automatic send_sample(input logic signed [15:0] si, input logic signed [15:0] sq);
		int gap;
		gap = src_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid    <= 1'b1;
		sample_ch.sample_i <= si;
		sample_ch.sample_q <= sq;
		do @(posedge clk); while (!sample_ch.ready);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [15:0] draw_component();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] draw_step();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($urandom_range(0, 1 << 24));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] draw_alpha();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [12:0] draw_factor();
		case ($urandom_range(0, 19))
			0, 1: return 13'd0;
			2, 3, 4: return 13'($urandom_range(4090, 8191));
			5, 6, 7, 8, 9: return 13'($urandom_range(5, 64));
			default: return 13'($urandom_range(1, 4));
		endcase
	endfunction

	// sink: stall a random number of cycles before each word
	initial begin
		int stall;
		int words;
		baseband_ch.ready <= 1'b0;
		sink_burst = 1'b0;
		words      = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (words % 40 == 0)
				sink_burst = ($urandom_range(0, 3) == 0);
			stall = sink_burst ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				baseband_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			baseband_ch.ready <= 1'b1;
			do @(posedge clk); while (!baseband_ch.valid);
			words++;
			@(negedge clk);
		end
	end

	initial begin
		int phase_no;
		arst_n             <= 1'b0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;
		sample_ch.valid    <= 1'b0;
		sample_ch.sample_i <= '0;
		sample_ch.sample_q <= '0;
		items_sent = 0;
		src_burst  = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings
		send_sample(16'sh7FFF, 16'sh7FFF);
		send_sample(-16'sh8000, -16'sh8000);

		// decimation factor zero, fastest phase step, full alpha
		configure(32'h7FFF_FFFF, 16'hFFFF, 13'd0);
		send_sample(16'sh7FFF, -16'sh8000);
		send_sample(-16'sh8000, 16'sh7FFF);
		send_sample(16'sh0000, 16'sh0000);
		send_sample(16'sh7FFF, 16'sh7FFF);
		send_sample(-16'sh8000, -16'sh8000);
		send_sample(16'sh0001, -16'sh0001);

		// alpha zero holds the filter
		configure(32'h8000_0000, 16'h0000, 13'd1);
		send_sample(16'sh7FFF, 16'sh7FFF);
		send_sample(-16'sh8000, 16'sh1234);
		send_sample(16'sh5555, -16'sh2AAA);

		// factor above the maximum, mixer saturation at the diagonal
		configure(32'h1000_0000, 16'hFFFF, 13'h1FFF);
		send_sample(-16'sh8000, -16'sh8000);
		send_sample(16'sh7FFF, 16'sh7FFF);
		send_sample(-16'sh8000, -16'sh8000);
		send_sample(16'sh3039, -16'sh5BA0);
		send_sample(-16'sh0001, 16'sh0001);

		// factor lowered below the running count
		configure(32'h1000_0000, 16'd40000, 13'd3);
		repeat (6) send_sample(draw_component(), draw_component());

		phase_no = 0;
		while (items_sent < 570 && phase_no < 60) begin
			configure(draw_step(), draw_alpha(), draw_factor());
			src_burst = ($urandom_range(0, 3) == 0);
			repeat (50) send_sample(draw_component(), draw_component());
			phase_no++;
		end

		sample_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("ddc_mixer_lowpass_decimator_core regression: pass");
		else
			$display("ddc_mixer_lowpass_decimator_core regression: fail");
		$finish;
	end

endmodule

### files.f
hw/rtl/ddc_pkg.sv
hw/rtl/ddc_channels.sv
hw/rtl/ddc_sine_rom.sv
hw/rtl/ddc_mixer_lowpass_decimator_core.sv
tb/ddc_baseband_checker.sv
tb/testbench.sv
